/* hdl/pd_pkg.sv */
// shared types and constants for the polyline densifier
// no dependencies
`default_nettype none
package pd_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int THRESH_WIDTH     = 16;
  localparam int THRESH_RESET     = 16;
  localparam int MAX_INTERP_DEF   = 62;
  // deltas at or beyond 2**SAT_BITS in magnitude saturate the point count
  localparam int SAT_BITS         = 22;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic                          end_of_stroke;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic                          last_point;
  } out_t;

  typedef struct packed {
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

/* hdl/polyline_densifier.sv */
// polyline densifier top level: sequencer, shared multiplier, emitter
// uses pd_pkg and pd_divider
// per vertex: squaring setup and count steps through the one shared multiplier
// (both skipped when a delta saturates), then two serial divisions, then the
// emitted points; in_ready is low the whole time, so a new vertex is not taken
// until every point of the one before has gone into the output register
// reset is synchronous: threshold back to 16, stored vertex cleared
`default_nettype none
module polyline_densifier #(
  parameter int MAX_INTERP = pd_pkg::MAX_INTERP_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire pd_pkg::in_t                 in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output pd_pkg::out_t                     out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [pd_pkg::THRESH_WIDTH-1:0]   cfg_data
);

  localparam int W  = pd_pkg::COORD_WIDTH;
  localparam int DW = W + 1;                      // delta width
  localparam int NW = $clog2(MAX_INTERP + 2);     // holds n and n+1
  localparam int SW = pd_pkg::THRESH_WIDTH + $clog2(MAX_INTERP + 1);
  localparam int MW = (SW > pd_pkg::SAT_BITS) ? SW : pd_pkg::SAT_BITS;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_SUM  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_DSX  = 4'd6;
  localparam logic [3:0] S_DWX  = 4'd7;
  localparam logic [3:0] S_DSY  = 4'd8;
  localparam logic [3:0] S_DWY  = 4'd9;
  localparam logic [3:0] S_PREV = 4'd10;
  localparam logic [3:0] S_INT  = 4'd11;
  localparam logic [3:0] S_LAST = 4'd12;

  logic [3:0] state;

  // configuration register, writable only between requests
  logic [pd_pkg::THRESH_WIDTH-1:0] thresh;
  assign cfg_ready = (state == S_IDLE);

  // stored vertex and the request being worked on
  logic signed [W-1:0] prev_x, prev_y, vx, vy;
  logic                have_prev, veos;

  // delta as sign and magnitude per axis
  logic          neg_x, neg_y;
  logic [DW-1:0] mag_x, mag_y;
  logic [DW-1:0] dx_in, dy_in;
  logic          sat_in;

  // distance test: shared multiplier and its operands
  logic [MW-1:0]   mul_a;
  logic [2*MW-1:0] prod;
  logic [2*MW:0]   d2;
  logic [SW-1:0]   s;
  logic [NW-1:0]   n;
  logic [NW-1:0]   n1;

  // base step quotient and remainder per axis
  logic [DW-1:0] qbx, qby;
  logic [NW-1:0] rbx, rby;

  // running quotient of j*|delta|/(n+1)
  logic [NW-1:0] j;
  logic [DW-1:0] qx, qy;
  logic [NW-1:0] rx, ry;

  // divider hookup
  logic                div_start;
  logic [DW-1:0]       div_dvd;
  pd_pkg::div_status_t div_st;
  logic [DW-1:0]       div_q;
  logic [NW-1:0]       div_r;

  logic slot_free;
  logic emit;
  assign slot_free = !out_valid || out_ready;
  // a point goes into the output register this cycle
  assign emit      = slot_free && (state inside {S_PREV, S_INT, S_LAST});
  assign in_ready  = (state == S_IDLE);
  assign n1        = n + 1'b1;

  // delta of the incoming vertex against the stored one
  assign dx_in = DW'(in_data.x_coord) - DW'(prev_x);
  assign dy_in = DW'(in_data.y_coord) - DW'(prev_y);

  function automatic logic [DW-1:0] absval(input logic [DW-1:0] v);
    absval = v[DW-1] ? -v : v;
  endfunction

  assign sat_in = (64'(absval(dx_in)) >= (64'd1 << pd_pkg::SAT_BITS)) ||
                  (64'(absval(dy_in)) >= (64'd1 << pd_pkg::SAT_BITS));

  // multiplier operand select: squares of deltas, then of the step sum
  always_comb begin
    case (state)
      S_SQX:   mul_a = MW'(mag_x);
      S_SQY:   mul_a = MW'(mag_y);
      default: mul_a = MW'(s);
    endcase
  end

  assign div_start = (state == S_DSX) || (state == S_DSY);
  assign div_dvd   = (state == S_DSX) ? mag_x : mag_y;

  pd_divider #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (NW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (n1),
    .status    (div_st),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // next intermediate point: add base step, carry the remainder
  logic [NW:0]   sum_rx, sum_ry;
  logic          cx, cy;
  logic [NW-1:0] rx_next, ry_next;
  logic [DW-1:0] qx_next, qy_next;
  logic [DW-1:0] px_full, py_full;

  always_comb begin
    sum_rx  = {1'b0, rx} + {1'b0, rbx};
    sum_ry  = {1'b0, ry} + {1'b0, rby};
    cx      = sum_rx >= {1'b0, n1};
    cy      = sum_ry >= {1'b0, n1};
    rx_next = cx ? NW'(sum_rx - {1'b0, n1}) : sum_rx[NW-1:0];
    ry_next = cy ? NW'(sum_ry - {1'b0, n1}) : sum_ry[NW-1:0];
    qx_next = qx + qbx + DW'(cx);
    qy_next = qy + qby + DW'(cy);
    px_full = DW'(prev_x) + (neg_x ? -qx_next : qx_next);
    py_full = DW'(prev_y) + (neg_y ? -qy_next : qy_next);
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      thresh    <= pd_pkg::THRESH_WIDTH'(pd_pkg::THRESH_RESET);
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thresh <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            vx    <= in_data.x_coord;
            vy    <= in_data.y_coord;
            veos  <= in_data.end_of_stroke;
            neg_x <= dx_in[DW-1];
            neg_y <= dy_in[DW-1];
            mag_x <= absval(dx_in);
            mag_y <= absval(dy_in);
            if (have_prev) begin
              if (sat_in) begin
                n     <= NW'(MAX_INTERP);
                state <= S_DSX;
              end else begin
                state <= S_SQX;
              end
            end else if (in_data.end_of_stroke) begin
              state <= S_LAST;
            end else begin
              prev_x    <= in_data.x_coord;
              prev_y    <= in_data.y_coord;
              have_prev <= 1'b1;
            end
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          // prod holds dx squared now
          d2    <= {1'b0, prod};
          state <= S_SUM;
        end
        S_SUM: begin
          d2    <= d2 + {1'b0, prod};
          s     <= SW'(thresh);
          n     <= '0;
          state <= S_MUL;
        end
        S_MUL: state <= S_CMP;
        S_CMP: begin
          // count how many multiples of the threshold fit in the distance
          if ({1'b0, prod} > d2) begin
            state <= S_DSX;
          end else begin
            n <= n1;
            s <= s + SW'(thresh);
            state <= (n1 == NW'(MAX_INTERP)) ? S_DSX : S_MUL;
          end
        end
        S_DSX: state <= S_DWX;
        S_DWX: begin
          if (div_st.done) begin
            qbx   <= div_q;
            rbx   <= div_r;
            state <= S_DSY;
          end
        end
        S_DSY: state <= S_DWY;
        S_DWY: begin
          if (div_st.done) begin
            qby   <= div_q;
            rby   <= div_r;
            state <= S_PREV;
          end
        end
        S_PREV: begin
          if (slot_free) begin
            out_data.out_x      <= prev_x;
            out_data.out_y      <= prev_y;
            out_data.last_point <= 1'b0;
            j  <= '0;
            qx <= '0;
            qy <= '0;
            rx <= '0;
            ry <= '0;
            if (n != '0) begin
              state <= S_INT;
            end else if (veos) begin
              state <= S_LAST;
            end else begin
              prev_x <= vx;
              prev_y <= vy;
              state  <= S_IDLE;
            end
          end
        end
        S_INT: begin
          if (slot_free) begin
            out_data.out_x      <= px_full[W-1:0];
            out_data.out_y      <= py_full[W-1:0];
            out_data.last_point <= 1'b0;
            qx <= qx_next;
            qy <= qy_next;
            rx <= rx_next;
            ry <= ry_next;
            j  <= j + 1'b1;
            if (j + 1'b1 == n) begin
              if (veos) begin
                state <= S_LAST;
              end else begin
                prev_x <= vx;
                prev_y <= vy;
                state  <= S_IDLE;
              end
            end
          end
        end
        S_LAST: begin
          if (slot_free) begin
            out_data.out_x      <= vx;
            out_data.out_y      <= vy;
            out_data.last_point <= 1'b1;
            prev_x    <= '0;
            prev_y    <= '0;
            have_prev <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/pd_divider.sv */
// restoring divider, one quotient bit per cycle
// uses pd_pkg for the status struct
`default_nettype none
module pd_divider #(
  parameter int DIVIDEND_W = 17,
  parameter int DIVISOR_W  = 6
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire [DIVIDEND_W-1:0]   dividend,
  input  wire [DIVISOR_W-1:0]    divisor,
  output pd_pkg::div_status_t    status,
  output logic [DIVIDEND_W-1:0]  quotient,
  output logic [DIVISOR_W-1:0]   remainder
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] dvd;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic                  done;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {remainder, dvd[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign status.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
      quotient  <= '0;
    end else if (busy) begin
      dvd       <= {dvd[DIVIDEND_W-2:0], 1'b0};
      remainder <= fits ? DIVISOR_W'(trial - {1'b0, dvs}) : trial[DIVISOR_W-1:0];
      quotient  <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

/* verif/testbench.sv */
// testbench for polyline_densifier: directed table then random strokes,
// every emitted point checked against a behavioral predictor
// depends on hdl/pd_pkg.sv, hdl/polyline_densifier.sv and hdl/pd_divider.sv
`timescale 1ns / 1ps
module testbench;

  localparam int MAXN = pd_pkg::MAX_INTERP_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pd_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pd_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pd_pkg::THRESH_WIDTH-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  polyline_densifier i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state: threshold and stored vertex
  logic [pd_pkg::THRESH_WIDTH-1:0] spacing = pd_pkg::THRESH_RESET;
  logic signed [pd_pkg::COORD_WIDTH-1:0] last_x = '0, last_y = '0;
  logic have_vertex = 1'b0;
  pd_pkg::out_t pending_points[$];
  int errors = 0;
  int stall = 0;
  bit quiet = 1'b0;

  task automatic report(input string what, input pd_pkg::out_t got,
                        input pd_pkg::out_t want);
    $display("mismatch %s: got x=%0d y=%0d l=%0b want x=%0d y=%0d l=%0b", what,
             got.out_x, got.out_y, got.last_point,
             want.out_x, want.out_y, want.last_point);
    errors++;
  endtask

  function automatic int segment_count(longint dx, longint dy, longint t);
    longint big, d2, s;
    int n;
    big = longint'(1) << pd_pkg::SAT_BITS;
    n = 0;
    if (dx >= big || -dx >= big || dy >= big || -dy >= big) return MAXN;
    d2 = dx * dx + dy * dy;
    while (n < MAXN) begin
      s = longint'(n + 1) * t;
      if (s * s > d2) break;
      n++;
    end
    return n;
  endfunction

  // push the points one vertex produces
  task automatic densify(input pd_pkg::in_t v);
    longint dx, dy;
    int n;
    pd_pkg::out_t p;
    if (have_vertex) begin
      dx = longint'(v.x_coord) - longint'(last_x);
      dy = longint'(v.y_coord) - longint'(last_y);
      n = segment_count(dx, dy, longint'(spacing));
      p = '{last_x, last_y, 1'b0};
      pending_points.push_back(p);
      for (int j = 1; j <= n; j++) begin
        p.out_x = pd_pkg::COORD_WIDTH'(longint'(last_x) + (j * dx) / (n + 1));
        p.out_y = pd_pkg::COORD_WIDTH'(longint'(last_y) + (j * dy) / (n + 1));
        pending_points.push_back(p);
      end
    end
    if (v.end_of_stroke) begin
      p = '{v.x_coord, v.y_coord, 1'b1};
      pending_points.push_back(p);
      last_x = '0; last_y = '0; have_vertex = 1'b0;
    end else begin
      last_x = v.x_coord; last_y = v.y_coord; have_vertex = 1'b1;
    end
  endtask

  // output side: random stall bursts unless quiet, check each accepted point
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          report("unexpected point", out_data, '0);
        end else begin
          if (out_data !== pending_points[0]) report("point", out_data, pending_points[0]);
          void'(pending_points.pop_front());
        end
      end
      if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 15) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // valid stays up between back-to-back requests; dropped only to idle
  task automatic send_vertex(input pd_pkg::in_t v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    densify(v);
  endtask

  // wait for drain, then write threshold once cfg_ready allows it
  task automatic set_spacing(input logic [pd_pkg::THRESH_WIDTH-1:0] t);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_points.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= t;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    spacing = t;
  endtask

  function automatic pd_pkg::in_t rand_vertex(input int span, input bit eos);
    pd_pkg::in_t v;
    int cx, cy;
    cx = $urandom_range(0, 65535) - 32768;
    cy = $urandom_range(0, 65535) - 32768;
    if (have_vertex && span > 0) begin
      cx = int'(last_x) + int'($urandom_range(0, 2 * span)) - span;
      cy = int'(last_y) + int'($urandom_range(0, 2 * span)) - span;
      if (cx > 32767) cx = 32767;
      if (cx < -32768) cx = -32768;
      if (cy > 32767) cy = 32767;
      if (cy < -32768) cy = -32768;
    end
    v.x_coord = pd_pkg::COORD_WIDTH'(cx);
    v.y_coord = pd_pkg::COORD_WIDTH'(cy);
    v.end_of_stroke = eos;
    return v;
  endfunction

  // directed rows: vertex, and a typed-in expectation where obvious
  typedef struct {
    pd_pkg::in_t v;
    bit has_want;
    pd_pkg::out_t want;
  } row_t;

  row_t rows[] = '{
    // single-vertex strokes: each is itself, flagged last
    '{'{16'sd0, 16'sd0, 1'b1}, 1, '{16'sd0, 16'sd0, 1'b1}},
    '{'{16'sh7fff, 16'sh8000, 1'b1}, 1, '{16'sh7fff, 16'sh8000, 1'b1}},
    // coincident vertices: previous then last only
    '{'{16'sd100, 16'sd100, 1'b0}, 0, '0},
    '{'{16'sd100, 16'sd100, 1'b1}, 0, '0},
    // short and diagonal segments
    '{'{16'sd0, 16'sd0, 1'b0}, 0, '0},
    '{'{16'sd64, 16'sd0, 1'b0}, 0, '0},
    '{'{16'sd64, 16'sd48, 1'b0}, 0, '0},
    '{'{-16'sd30, -16'sd77, 1'b1}, 0, '0},
    // full-range corners, point count capped at the maximum for small thresholds
    '{'{16'sh8000, 16'sh8000, 1'b0}, 0, '0},
    '{'{16'sh7fff, 16'sh7fff, 1'b0}, 0, '0},
    '{'{16'sh8000, 16'sh7fff, 1'b0}, 0, '0},
    '{'{16'sh7fff, 16'sh8000, 1'b1}, 0, '0},
    '{'{16'sh5555, 16'shaaaa, 1'b0}, 0, '0},
    '{'{16'shaaaa, 16'sh5555, 1'b1}, 0, '0}
  };

  task automatic run_rows();
    pd_pkg::out_t want;
    foreach (rows[i]) begin
      if (rows[i].has_want) want = rows[i].want;
      send_vertex(rows[i].v);
      if (rows[i].has_want && pending_points[$] !== want)
        report("table row", pending_points[$], want);
    end
  endtask

  task automatic random_strokes(input int count);
    int left, len, span;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 6);
      span = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 600);
      for (int k = 0; k < len && left > 0; k++) begin
        send_vertex(rand_vertex(span, k == len - 1));
        left--;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_rows();
    set_spacing(16'd1);
    run_rows();
    random_strokes(30);
    set_spacing(16'hffff);
    run_rows();
    random_strokes(20);
    set_spacing(16'd0);
    random_strokes(20);
    set_spacing(16'd40);
    random_strokes(40);
    quiet = 1'b1;
    set_spacing(16'd16);
    random_strokes(30);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
